// File: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold in the same cycle as its trigger
`define RLZ_ASSERT_SAME(label, clk, rst_n, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error(msg);

// property must hold in the cycle after its trigger
`define RLZ_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// File: hdl/rlz_pkg.sv
// types, constants and decode helpers of the lz decompressor
package rlz_pkg;

    typedef enum logic [3:0] {
        PH_SIG0,
        PH_SIG1,
        PH_CSIZE,
        PH_DSIZE,
        PH_OP,
        PH_CMDX,
        PH_LIT,
        PH_COPY,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_REF,
        ST_AFTER_STOP,
        ST_IDLE_DRAIN
    } t_status;

    // where the stage-1 byte comes from
    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_RAM,
        SRC_LAST
    } t_src;

    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_DRAIN = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    localparam logic [6:0]  LIT_LIMIT       = 7'h70;
    localparam logic [10:0] COPY_MAX        = 11'd1028;
    localparam logic [2:0]  HDR_FIELD_BYTES = 3'd3;

    typedef struct packed {
        logic [6:0]  lit;
        logic [10:0] copy;
        logic [17:0] ref_dist;
        logic        stop;
    } t_dec;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_valid;
        logic [10:0] copy_left;
        logic [6:0]  literals_left;
        logic        stream_done;
        t_status     status;
        logic [23:0] declared_size;
        logic [23:0] bytes_consumed;
    } t_res;

    function automatic logic [2:0] cmd_len(input logic [7:0] b0);
        logic [2:0] len;
        if (!b0[7]) begin
            len = 3'd2;
        end else if (!b0[6]) begin
            len = 3'd3;
        end else if (!b0[5]) begin
            len = 3'd4;
        end else begin
            len = 3'd1;
        end
        return len;
    endfunction

    function automatic t_dec decode(input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2, input logic [7:0] b3);
        t_dec       d;
        logic [7:0] n;
        d = '0;
        // n reaches 128, past the 7-bit literal count; n over 112 means stop
        n = {1'b0, b0[4:0], 2'b00} + 8'd4;
        if (!b0[7]) begin
            d.lit      = 7'(b0[1:0]);
            d.ref_dist = 18'({b0[6:5], 8'h00}) + 18'(b1) + 18'd1;
            d.copy     = 11'(b0[4:2]) + 11'd3;
        end else if (!b0[6]) begin
            d.lit      = 7'(b1[7:6]);
            d.ref_dist = 18'({b1[5:0], b2}) + 18'd1;
            d.copy     = 11'(b0[5:0]) + 11'd4;
        end else if (!b0[5]) begin
            d.lit      = 7'(b0[1:0]);
            d.ref_dist = 18'({b0[4], b1, b2}) + 18'd1;
            d.copy     = 11'({b0[3:2], 8'h00}) + 11'(b3) + 11'd5;
        end else if (n <= 8'(LIT_LIMIT)) begin
            d.lit = n[6:0];
        end else begin
            // stop command: a few trailing literals, then done
            d.lit  = 7'(b0[1:0]);
            d.stop = 1'b1;
        end
        return d;
    endfunction

    function automatic t_phase next_phase(input logic [6:0] lit, input logic stop,
                                          input logic [10:0] copy);
        t_phase ph;
        if (lit != 7'd0) begin
            ph = PH_LIT;
        end else if (stop) begin
            ph = PH_DONE;
        end else if (copy != 11'd0) begin
            ph = PH_COPY;
        end else begin
            ph = PH_OP;
        end
        return ph;
    endfunction

endpackage

// File: hdl/rlz_ifs.sv
// request and result channel interfaces of the lz decompressor
interface rlz_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] in_byte;

    modport source (output valid, output cmd, output in_byte, input ready);
    modport sink (input valid, input cmd, input in_byte, output ready);
endinterface

interface rlz_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        out_valid;
    logic [10:0] copy_left;
    logic [6:0]  literals_left;
    logic        stream_done;
    logic [1:0]  status;
    logic [23:0] declared_size;
    logic [23:0] bytes_consumed;

    modport source (output valid, output out_byte, output out_valid, output copy_left,
                    output literals_left, output stream_done, output status,
                    output declared_size, output bytes_consumed, input ready);
    modport sink (input valid, input out_byte, input out_valid, input copy_left,
                  input literals_left, input stream_done, input status,
                  input declared_size, input bytes_consumed, output ready);
endinterface

// File: hdl/rlz_ram.sv
// generic single-port-write, single-port-read ram with registered read
module rlz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/refpack_lz_decompressor_unit.sv
// top level of the refpack lz decompressor: parser, window ram and result pipeline
//
// usage
//   i_in_ch carries one request per handshake: cmd 0 feeds one compressed byte,
//   cmd 1 drains one pending back-reference byte, cmd 2 starts a new stream.
//   every accepted request gives exactly one result on o_out_ch, in order.
//   the result reports the decoded byte (out_valid) and the parser state after
//   the request: pending copy and literal counts, done flag, status, header size
//   and compressed byte count.
// timing
//   a request passes stage one, then the result register that drives o_out_ch.
//   one request per cycle is sustained while o_out_ch.ready is high; the window
//   ram is read and written at most once per request, and a drain at distance
//   one (the byte of the request just ahead) is forwarded from a holding register.
// reset
//   synchronous, active low; parser state and channel valids clear at once.
//   the window contents are not cleared, and no read of an unwritten entry can
//   reach the output: references before the start of output yield zero.
// backpressure
//   the result register holds while o_out_ch.ready is low; the request side
//   keeps taking requests until stage one is also full, then drops ready.
module refpack_lz_decompressor_unit #(
    parameter int WINDOW_DEPTH = 131072,
    parameter int COUNT_BITS   = 24
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rlz_in_if.sink   i_in_ch,
    rlz_out_if.source o_out_ch
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int IW = AW + 1;

    // parser state
    rlz_pkg::t_phase         r_phase, n_phase;
    logic [2:0]              r_hbs, n_hbs;
    logic                    r_has_size, n_has_size;
    logic [7:0]              r_cb [4];
    logic [7:0]              n_cb [4];
    logic [6:0]              r_lit, n_lit;
    logic [10:0]             r_copy, n_copy;
    logic [17:0]             r_dist, n_dist;
    logic                    r_stop, n_stop;
    logic [AW-1:0]           r_wptr, n_wptr;
    logic [COUNT_BITS-1:0]   r_outcnt, n_outcnt;
    logic [23:0]             r_size, n_size;
    logic [COUNT_BITS-1:0]   r_consumed, n_consumed;

    // stage one: window read in flight
    logic                    r_s1_vld;
    rlz_pkg::t_src           r_s1_src;
    logic [7:0]              r_s1_data;
    logic                    r_s1_emit;
    logic [AW-1:0]           r_s1_waddr;
    rlz_pkg::t_res           r_s1_res;

    // result register
    logic                    r_out_vld;
    rlz_pkg::t_res           r_out;

    // last byte written, for distance-one forwarding
    logic [7:0]              r_last;

    // request-stage combinational signals
    logic                    in_ready;
    logic                    accept;
    logic                    s1_adv;
    logic                    emit;
    rlz_pkg::t_src           src;
    logic [7:0]              data;
    logic                    rd_en;
    rlz_pkg::t_status        status;
    rlz_pkg::t_dec           dec;
    logic                    bad_ref;
    logic [IW-1:0]           rd_sum;
    logic [AW-1:0]           rd_addr;
    logic                    fwd;
    logic [31:0]             consumed_ext;
    rlz_pkg::t_res           res;

    // stage-one combinational signals
    logic [7:0]              ram_rdata;
    logic [7:0]              s1_byte;
    logic                    ram_we;
    rlz_pkg::t_res           s1_res;

    // handshake: stage one frees up whenever the result register can take it
    assign s1_adv        = !r_out_vld || o_out_ch.ready;
    assign in_ready      = !r_s1_vld || s1_adv;
    assign accept        = i_in_ch.valid && in_ready;
    assign i_in_ch.ready = in_ready;

    // read address: write pointer minus distance, modulo window depth
    assign rd_sum  = IW'(r_wptr) + IW'(WINDOW_DEPTH) - IW'(r_dist);
    assign rd_addr = (rd_sum >= IW'(WINDOW_DEPTH)) ? AW'(rd_sum - IW'(WINDOW_DEPTH))
                                                   : AW'(rd_sum);
    assign bad_ref = 32'(r_dist) > 32'(r_outcnt);
    // the request ahead writes its byte at this same edge, so take it from r_last
    assign fwd     = r_s1_vld && r_s1_emit && (r_s1_waddr == rd_addr);

    always_comb begin
        n_phase    = r_phase;
        n_hbs      = r_hbs;
        n_has_size = r_has_size;
        n_cb       = r_cb;
        n_lit      = r_lit;
        n_copy     = r_copy;
        n_dist     = r_dist;
        n_stop     = r_stop;
        n_wptr     = r_wptr;
        n_outcnt   = r_outcnt;
        n_size     = r_size;
        n_consumed = r_consumed;
        emit       = 1'b0;
        src        = rlz_pkg::SRC_DATA;
        data       = 8'h00;
        rd_en      = 1'b0;
        status     = rlz_pkg::ST_OK;
        dec        = '0;

        if (accept) begin
            case (i_in_ch.cmd)
                rlz_pkg::CMD_START: begin
                    n_phase    = rlz_pkg::PH_SIG0;
                    n_hbs      = 3'd0;
                    n_has_size = 1'b0;
                    n_cb       = '{default: 8'h00};
                    n_lit      = 7'd0;
                    n_copy     = 11'd0;
                    n_dist     = 18'd0;
                    n_stop     = 1'b0;
                    n_wptr     = '0;
                    n_outcnt   = '0;
                    n_size     = 24'd0;
                    n_consumed = '0;
                end
                rlz_pkg::CMD_DRAIN: begin
                    if (r_phase == rlz_pkg::PH_COPY && r_copy != 11'd0) begin
                        emit = 1'b1;
                        if (bad_ref) begin
                            status = rlz_pkg::ST_BAD_REF;
                        end else begin
                            rd_en = 1'b1;
                            src   = fwd ? rlz_pkg::SRC_LAST : rlz_pkg::SRC_RAM;
                        end
                        n_copy = r_copy - 11'd1;
                        if (n_copy == 11'd0) begin
                            n_phase = rlz_pkg::PH_OP;
                        end
                    end else begin
                        status = rlz_pkg::ST_IDLE_DRAIN;
                    end
                end
                rlz_pkg::CMD_BYTE: begin
                    if (r_phase == rlz_pkg::PH_DONE) begin
                        status = rlz_pkg::ST_AFTER_STOP;
                    end else if (r_phase != rlz_pkg::PH_COPY) begin
                        if (r_consumed != {COUNT_BITS{1'b1}}) begin
                            n_consumed = r_consumed + COUNT_BITS'(1);
                        end
                        case (r_phase)
                            rlz_pkg::PH_SIG0: begin
                                n_has_size = i_in_ch.in_byte[0];
                                n_phase    = rlz_pkg::PH_SIG1;
                            end
                            rlz_pkg::PH_SIG1: begin
                                n_hbs   = 3'd0;
                                n_phase = r_has_size ? rlz_pkg::PH_CSIZE : rlz_pkg::PH_DSIZE;
                            end
                            rlz_pkg::PH_CSIZE: begin
                                n_hbs = r_hbs + 3'd1;
                                if (n_hbs >= rlz_pkg::HDR_FIELD_BYTES) begin
                                    n_hbs   = 3'd0;
                                    n_phase = rlz_pkg::PH_DSIZE;
                                end
                            end
                            rlz_pkg::PH_DSIZE: begin
                                n_size = {r_size[15:0], i_in_ch.in_byte};
                                n_hbs  = r_hbs + 3'd1;
                                if (n_hbs >= rlz_pkg::HDR_FIELD_BYTES) begin
                                    n_hbs   = 3'd0;
                                    n_phase = rlz_pkg::PH_OP;
                                end
                            end
                            rlz_pkg::PH_OP: begin
                                n_cb[0] = i_in_ch.in_byte;
                                if (rlz_pkg::cmd_len(i_in_ch.in_byte) == 3'd1) begin
                                    dec     = rlz_pkg::decode(n_cb[0], n_cb[1], n_cb[2], n_cb[3]);
                                    n_lit   = dec.lit;
                                    n_copy  = dec.copy;
                                    n_dist  = dec.ref_dist;
                                    n_stop  = r_stop | dec.stop;
                                    n_phase = rlz_pkg::next_phase(dec.lit, n_stop, dec.copy);
                                end else begin
                                    n_hbs   = 3'd1;
                                    n_phase = rlz_pkg::PH_CMDX;
                                end
                            end
                            rlz_pkg::PH_CMDX: begin
                                n_cb[r_hbs[1:0]] = i_in_ch.in_byte;
                                n_hbs            = r_hbs + 3'd1;
                                if (n_hbs >= rlz_pkg::cmd_len(r_cb[0])) begin
                                    n_hbs   = 3'd0;
                                    dec     = rlz_pkg::decode(n_cb[0], n_cb[1], n_cb[2], n_cb[3]);
                                    n_lit   = dec.lit;
                                    n_copy  = dec.copy;
                                    n_dist  = dec.ref_dist;
                                    n_stop  = r_stop | dec.stop;
                                    n_phase = rlz_pkg::next_phase(dec.lit, n_stop, dec.copy);
                                end
                            end
                            rlz_pkg::PH_LIT: begin
                                emit  = 1'b1;
                                data  = i_in_ch.in_byte;
                                n_lit = (r_lit != 7'd0) ? r_lit - 7'd1 : 7'd0;
                                n_phase = rlz_pkg::next_phase(n_lit, r_stop, r_copy);
                            end
                            default: begin
                            end
                        endcase
                    end
                    // a compressed byte while a copy is due is dropped silently
                end
                default: begin
                end
            endcase

            if (emit) begin
                n_wptr = (r_wptr == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wptr + AW'(1);
                if (r_outcnt != {COUNT_BITS{1'b1}}) begin
                    n_outcnt = r_outcnt + COUNT_BITS'(1);
                end
            end
        end
    end

    // result fields known at request time; the byte itself is settled in stage one
    assign consumed_ext = 32'(n_consumed);

    always_comb begin
        res                = '0;
        res.out_valid      = emit;
        res.copy_left      = n_copy;
        res.literals_left  = n_lit;
        res.stream_done    = (n_phase == rlz_pkg::PH_DONE);
        res.status         = status;
        res.declared_size  = n_size;
        res.bytes_consumed = consumed_ext[23:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= rlz_pkg::PH_SIG0;
            r_hbs      <= 3'd0;
            r_has_size <= 1'b0;
            r_cb       <= '{default: 8'h00};
            r_lit      <= 7'd0;
            r_copy     <= 11'd0;
            r_dist     <= 18'd0;
            r_stop     <= 1'b0;
            r_wptr     <= '0;
            r_outcnt   <= '0;
            r_size     <= 24'd0;
            r_consumed <= '0;
        end else begin
            r_phase    <= n_phase;
            r_hbs      <= n_hbs;
            r_has_size <= n_has_size;
            r_cb       <= n_cb;
            r_lit      <= n_lit;
            r_copy     <= n_copy;
            r_dist     <= n_dist;
            r_stop     <= n_stop;
            r_wptr     <= n_wptr;
            r_outcnt   <= n_outcnt;
            r_size     <= n_size;
            r_consumed <= n_consumed;
        end
    end

    // history window
    rlz_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_waddr),
        .i_wdata (s1_byte),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // stage one: pick the byte, write it back to the window
    always_comb begin
        case (r_s1_src)
            rlz_pkg::SRC_RAM:  s1_byte = ram_rdata;
            rlz_pkg::SRC_LAST: s1_byte = r_last;
            default:           s1_byte = r_s1_data;
        endcase
    end

    always_comb begin
        s1_res          = r_s1_res;
        s1_res.out_byte = r_s1_emit ? s1_byte : 8'h00;
    end

    assign ram_we = r_s1_vld && s1_adv && r_s1_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_ready) begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_src   <= src;
            r_s1_data  <= data;
            r_s1_emit  <= emit;
            r_s1_waddr <= r_wptr;
            r_s1_res   <= res;
        end
        if (ram_we) begin
            r_last <= s1_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_vld) begin
            r_out <= s1_res;
        end
    end

    assign o_out_ch.valid          = r_out_vld;
    assign o_out_ch.out_byte       = r_out.out_byte;
    assign o_out_ch.out_valid      = r_out.out_valid;
    assign o_out_ch.copy_left      = r_out.copy_left;
    assign o_out_ch.literals_left  = r_out.literals_left;
    assign o_out_ch.stream_done    = r_out.stream_done;
    assign o_out_ch.status         = r_out.status;
    assign o_out_ch.declared_size  = r_out.declared_size;
    assign o_out_ch.bytes_consumed = r_out.bytes_consumed;

endmodule

// File: hdl/rlz_checker.sv
// port-level checks of the lz decompressor, bound to the top level
`include "assert_macros.svh"

module rlz_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_vld,
    input logic        i_rdy,
    input logic [7:0]  i_out_byte,
    input logic        i_out_valid,
    input logic [10:0] i_copy_left,
    input logic [6:0]  i_literals_left,
    input logic        i_stream_done,
    input logic [1:0]  i_status
);

    // a stalled result keeps its byte and status
    `RLZ_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_vld && !i_rdy, i_vld && $stable(i_out_byte) && $stable(i_status), "result changed while stalled")

    // no decoded byte means a zero byte field
    `RLZ_ASSERT_SAME(a_idle_byte_zero, i_clk, i_rst_n, i_vld && !i_out_valid, i_out_byte == 8'h00, "byte field nonzero without a byte")

    // a finished stream has nothing pending
    `RLZ_ASSERT_SAME(a_done_empty, i_clk, i_rst_n, i_vld && i_stream_done, i_copy_left == 11'd0 && i_literals_left == 7'd0, "stream done with work pending")

    // a byte comes only with an ok or early-reference status
    `RLZ_ASSERT_SAME(a_byte_status, i_clk, i_rst_n, i_vld && i_out_valid, i_status == rlz_pkg::ST_OK || i_status == rlz_pkg::ST_BAD_REF, "byte with error status")

    // copy count never exceeds the longest command
    `RLZ_ASSERT_SAME(a_copy_range, i_clk, i_rst_n, i_vld, i_copy_left <= rlz_pkg::COPY_MAX, "copy count out of range")

endmodule

bind refpack_lz_decompressor_unit rlz_checker u_rlz_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_vld           (o_out_ch.valid),
    .i_rdy           (o_out_ch.ready),
    .i_out_byte      (o_out_ch.out_byte),
    .i_out_valid     (o_out_ch.out_valid),
    .i_copy_left     (o_out_ch.copy_left),
    .i_literals_left (o_out_ch.literals_left),
    .i_stream_done   (o_out_ch.stream_done),
    .i_status        (o_out_ch.status)
);
